>>> hdl/round_robin_schedule_sim_unit_assert.svh
// assertion macros used by the round-robin scheduler controller
`ifndef ROUND_ROBIN_SCHEDULE_SIM_UNIT_ASSERT_SVH
`define ROUND_ROBIN_SCHEDULE_SIM_UNIT_ASSERT_SVH

// clocked assertion, held off while reset is low
`define RRS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked assertion that also holds during reset
`define RRS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/rrs_pkg.sv
// shared constants and control types for the round-robin scheduler
`timescale 1ns / 1ps
`default_nettype none
package rrs_pkg;
    localparam int MAX_JOBS   = 16;
    localparam int TIME_WIDTH = 16;
    localparam int JOB_W      = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CNT_W      = $clog2(MAX_JOBS + 1);
    localparam int TICK_W     = 21;
    localparam int IDX_W      = 4;
    localparam logic [15:0] QUANTUM_RESET = 16'd2;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic idle_tick;
        logic take;
        logic run;
        logic retire;
        logic out_load;
        logic clear;
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic scan_last;
        logic ring_empty;
        logic all_done;
        logic out_last;
    } t_status;
endpackage
`default_nettype wire

>>> hdl/rrs_datapath.sv
// job stores, ready ring, tick counter and result registers
`timescale 1ns / 1ps
`default_nettype none
module rrs_datapath (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire rrs_pkg::t_cmd                     i_cmd,
    output rrs_pkg::t_status                       o_status,
    input  wire logic                              i_cfg_we,
    input  wire logic [15:0]                       i_cfg_wdata,
    input  wire logic [rrs_pkg::TIME_WIDTH-1:0]    i_arrival_time,
    input  wire logic [rrs_pkg::TIME_WIDTH-1:0]    i_burst_time,
    output logic [rrs_pkg::IDX_W-1:0]              o_job_index,
    output logic [rrs_pkg::TICK_W-1:0]             o_completion_tick,
    output logic [rrs_pkg::TICK_W-1:0]             o_turnaround_ticks,
    output logic [rrs_pkg::TICK_W-1:0]             o_waiting_ticks,
    output logic                                   o_last_result
);
    localparam int JW = rrs_pkg::JOB_W;
    localparam int CW = rrs_pkg::CNT_W;
    localparam int TW = rrs_pkg::TIME_WIDTH;
    localparam int KW = rrs_pkg::TICK_W;
    localparam int N  = rrs_pkg::MAX_JOBS;

    logic [TW-1:0] r_arr  [N];
    logic [TW-1:0] r_bur  [N];
    logic [TW-1:0] r_rem  [N];
    logic [KW-1:0] r_comp [N];
    logic [JW-1:0] r_ring [N];
    logic [N-1:0]  r_flag;

    logic [15:0]   r_quantum;
    logic [JW-1:0] r_head, r_tail, r_idx, r_oidx, r_job;
    logic [CW-1:0] r_count, r_loaded, r_done;
    logic [KW-1:0] r_tick;

    logic [JW-1:0] arr_addr;
    logic [TW-1:0] arr_rd, rem_rd, slice, q_eff;
    logic          admit;
    logic [KW-1:0] ta, wt;

    assign arr_addr = i_cmd.out_load ? r_oidx : r_idx;
    assign arr_rd   = r_arr[arr_addr];
    assign rem_rd   = r_rem[r_job];
    assign q_eff    = (r_quantum == 16'd0) ? TW'(1) : TW'(r_quantum);
    assign slice    = (rem_rd < q_eff) ? rem_rd : q_eff;
    assign admit    = !r_flag[r_idx] && (KW'(arr_rd) <= r_tick);
    assign ta       = r_comp[r_oidx] - KW'(arr_rd);
    assign wt       = ta - KW'(r_bur[r_oidx]);

    assign o_status.scan_last  = (CW'(r_idx) + CW'(1)) == r_loaded;
    assign o_status.ring_empty = (r_count == '0);
    assign o_status.all_done   = (r_done >= r_loaded);
    assign o_status.out_last   = o_last_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quantum <= rrs_pkg::QUANTUM_RESET;
        end else if (i_cfg_we) begin
            r_quantum <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_flag   <= '0;
            r_head   <= '0;
            r_tail   <= '0;
            r_count  <= '0;
            r_loaded <= '0;
            r_done   <= '0;
            r_tick   <= '0;
            r_idx    <= '0;
            r_oidx   <= '0;
        end else begin
            if (i_cmd.load && r_loaded < CW'(N)) begin
                r_arr[r_loaded[JW-1:0]] <= i_arrival_time;
                r_bur[r_loaded[JW-1:0]] <= i_burst_time;
                r_rem[r_loaded[JW-1:0]] <= i_burst_time;
                r_loaded <= r_loaded + CW'(1);
            end
            if (i_cmd.scan) begin
                if (admit && r_count < CW'(N)) begin
                    r_ring[r_tail] <= r_idx;
                    r_tail  <= (r_tail == JW'(N - 1)) ? '0 : r_tail + JW'(1);
                    r_count <= r_count + CW'(1);
                    r_flag[r_idx] <= 1'b1;
                end
                r_idx <= o_status.scan_last ? '0 : r_idx + JW'(1);
            end
            if (i_cmd.idle_tick) begin
                r_tick <= r_tick + KW'(1);
            end
            if (i_cmd.take) begin
                r_job   <= r_ring[r_head];
                r_head  <= (r_head == JW'(N - 1)) ? '0 : r_head + JW'(1);
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.run) begin
                r_tick       <= r_tick + KW'(slice);
                r_rem[r_job] <= rem_rd - slice;
            end
            if (i_cmd.retire) begin
                if (rem_rd != '0) begin
                    if (r_count < CW'(N)) begin
                        r_ring[r_tail] <= r_job;
                        r_tail  <= (r_tail == JW'(N - 1)) ? '0 : r_tail + JW'(1);
                        r_count <= r_count + CW'(1);
                    end
                end else begin
                    r_comp[r_job] <= r_tick;
                    r_done <= r_done + CW'(1);
                end
            end
            if (i_cmd.out_load) begin
                r_oidx <= r_oidx + JW'(1);
            end
        end
    end

    // result word registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_job_index        <= rrs_pkg::IDX_W'(r_oidx);
            o_completion_tick  <= r_comp[r_oidx];
            o_turnaround_ticks <= ta;
            o_waiting_ticks    <= wt;
            o_last_result      <= (CW'(r_oidx) + CW'(1)) == r_loaded;
        end
    end
endmodule
`default_nettype wire

>>> hdl/rrs_controller.sv
// sequencer for loading, round-robin simulation and result output
`timescale 1ns / 1ps
`default_nettype none
`include "round_robin_schedule_sim_unit_assert.svh"
module rrs_controller (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic             i_last_job,
    input  wire logic             i_out_stall,
    input  wire rrs_pkg::t_status i_status,
    output rrs_pkg::t_cmd         o_cmd,
    output logic                  o_in_stall,
    output logic                  o_out_valid
);
    typedef enum logic [3:0] {
        S_LOAD, S_CHECK, S_SCAN1, S_DECIDE, S_RUN, S_SCAN2, S_RETIRE,
        S_OUT_LOAD, S_OUT_WAIT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    assign o_in_stall  = (r_state != S_LOAD);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd       = '0;
        n_state     = r_state;
        n_out_valid = r_out_valid;
        case (r_state)
            S_LOAD: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_last_job) n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = i_status.all_done ? S_OUT_LOAD : S_SCAN1;
            end
            S_SCAN1: begin
                o_cmd.scan = 1'b1;
                if (i_status.scan_last) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (i_status.ring_empty) begin
                    o_cmd.idle_tick = 1'b1;
                    n_state = S_CHECK;
                end else begin
                    o_cmd.take = 1'b1;
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                o_cmd.run = 1'b1;
                n_state = S_SCAN2;
            end
            S_SCAN2: begin
                o_cmd.scan = 1'b1;
                if (i_status.scan_last) n_state = S_RETIRE;
            end
            S_RETIRE: begin
                o_cmd.retire = 1'b1;
                n_state = S_CHECK;
            end
            S_OUT_LOAD: begin
                o_cmd.out_load = 1'b1;
                n_out_valid = 1'b1;
                n_state = S_OUT_WAIT;
            end
            S_OUT_WAIT: begin
                if (!i_out_stall) begin
                    n_out_valid = 1'b0;
                    if (i_status.out_last) begin
                        o_cmd.clear = 1'b1;
                        n_state = S_LOAD;
                    end else begin
                        n_state = S_OUT_LOAD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
                n_out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `RRS_ASSERT(a_one_word, i_clk, i_rst_n, r_out_valid && !i_out_stall |=> !r_out_valid, "word repeated")
    `RRS_ASSERT(a_hold_word, i_clk, i_rst_n, r_out_valid && i_out_stall |=> r_out_valid, "word lost")
    `RRS_ASSERT(a_no_overlap, i_clk, i_rst_n, !o_in_stall |-> !r_out_valid, "input taken with results due")
endmodule
`default_nettype wire

>>> hdl/round_robin_schedule_sim_unit.sv
// top level of the round-robin scheduling simulator
// Jobs load at one word per cycle. The word marked last_job starts the
// simulation; input stays stalled until every result word is taken. Each
// scheduling pass checks arrivals one job per cycle over the N loaded jobs,
// then either adds one tick of idle time when the ready ring is empty, or
// takes a job, runs its slice, checks arrivals again and requeues or retires
// the job. Results then leave in load order, each word held until taken.
// Writing time_quantum is only safe while the block waits for input.
`timescale 1ns / 1ps
`default_nettype none
module round_robin_schedule_sim_unit (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [15:0]                    i_cfg_wdata,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [rrs_pkg::TIME_WIDTH-1:0] i_arrival_time,
    input  wire logic [rrs_pkg::TIME_WIDTH-1:0] i_burst_time,
    input  wire logic                           i_last_job,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [rrs_pkg::IDX_W-1:0]           o_job_index,
    output logic [rrs_pkg::TICK_W-1:0]          o_completion_tick,
    output logic [rrs_pkg::TICK_W-1:0]          o_turnaround_ticks,
    output logic [rrs_pkg::TICK_W-1:0]          o_waiting_ticks,
    output logic                                o_last_result
);
    rrs_pkg::t_cmd    cmd;
    rrs_pkg::t_status status;

    rrs_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_last_job  (i_last_job),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    rrs_datapath u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_arrival_time     (i_arrival_time),
        .i_burst_time       (i_burst_time),
        .o_job_index        (o_job_index),
        .o_completion_tick  (o_completion_tick),
        .o_turnaround_ticks (o_turnaround_ticks),
        .o_waiting_ticks    (o_waiting_ticks),
        .o_last_result      (o_last_result)
    );
endmodule
`default_nettype wire

>>> verif/round_robin_schedule_sim_unit_tb.sv
// self-checking testbench for the round-robin scheduling simulator
`timescale 1ns / 1ps
`default_nettype none
module round_robin_schedule_sim_unit_tb;

    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int SETTLE_CYCLES = 40;
    localparam int ITEM_TARGET = 160;

    typedef struct {
        logic [rrs_pkg::IDX_W-1:0]  job_index;
        logic [rrs_pkg::TICK_W-1:0] completion;
        logic [rrs_pkg::TICK_W-1:0] turnaround;
        logic [rrs_pkg::TICK_W-1:0] waiting;
        logic                       last_result;
    } t_sched_rec;

    // schedule predictor and the queue of job records it expects
    class sched_scoreboard;
        t_sched_rec  pending_recs[$];
        int unsigned quantum;
        int unsigned arr_q[rrs_pkg::MAX_JOBS];
        int unsigned bur_q[rrs_pkg::MAX_JOBS];
        int unsigned jobs_in;
        int          errors;
        int          words_seen;
        int          lists_done;

        function new();
            quantum = 32'(rrs_pkg::QUANTUM_RESET);
            jobs_in = 0;
            errors = 0;
            words_seen = 0;
            lists_done = 0;
        endfunction

        task report(string what, int unsigned got, int unsigned exp);
            $display("mismatch %s: got %0d expected %0d", what, got, exp);
            errors++;
        endtask

        function int pending();
            return pending_recs.size();
        endfunction

        function void note_job(int unsigned arr, int unsigned bur, bit last);
            int unsigned rem[rrs_pkg::MAX_JOBS];
            int unsigned fin[rrs_pkg::MAX_JOBS];
            bit          queued[rrs_pkg::MAX_JOBS];
            int unsigned ring[rrs_pkg::MAX_JOBS];
            int unsigned head, tail, cnt, tick, done, q, job, slice, n;
            t_sched_rec  rec;
            if (jobs_in < rrs_pkg::MAX_JOBS) begin
                arr_q[jobs_in] = arr;
                bur_q[jobs_in] = bur;
                jobs_in++;
            end
            if (!last) return;
            n = jobs_in;
            q = (quantum == 0) ? 1 : quantum;
            head = 0; tail = 0; cnt = 0; tick = 0; done = 0;
            for (int i = 0; i < rrs_pkg::MAX_JOBS; i++) begin
                queued[i] = 0;
                rem[i] = bur_q[i];
                fin[i] = 0;
            end
            while (done < n) begin
                for (int i = 0; i < n; i++)
                    if (!queued[i] && arr_q[i] <= tick && cnt < rrs_pkg::MAX_JOBS) begin
                        ring[tail] = i; tail = (tail + 1) % rrs_pkg::MAX_JOBS; cnt++;
                        queued[i] = 1;
                    end
                if (cnt == 0) begin
                    tick++;
                    continue;
                end
                job = ring[head]; head = (head + 1) % rrs_pkg::MAX_JOBS; cnt--;
                slice = (rem[job] < q) ? rem[job] : q;
                tick += slice;
                rem[job] -= slice;
                // late arrivals go ahead of the preempted job
                for (int i = 0; i < n; i++)
                    if (!queued[i] && arr_q[i] <= tick && cnt < rrs_pkg::MAX_JOBS) begin
                        ring[tail] = i; tail = (tail + 1) % rrs_pkg::MAX_JOBS; cnt++;
                        queued[i] = 1;
                    end
                if (rem[job] > 0) begin
                    ring[tail] = job; tail = (tail + 1) % rrs_pkg::MAX_JOBS; cnt++;
                end else begin
                    fin[job] = tick;
                    done++;
                end
            end
            for (int i = 0; i < n; i++) begin
                rec.job_index   = rrs_pkg::IDX_W'(i);
                rec.completion  = rrs_pkg::TICK_W'(fin[i]);
                rec.turnaround  = rrs_pkg::TICK_W'(fin[i] - arr_q[i]);
                rec.waiting     = rrs_pkg::TICK_W'(fin[i] - arr_q[i] - bur_q[i]);
                rec.last_result = (i + 1 == n);
                pending_recs.push_back(rec);
            end
            jobs_in = 0;
            lists_done++;
        endfunction

        task check(t_sched_rec got);
            t_sched_rec exp;
            words_seen++;
            if (pending_recs.size() == 0) begin
                $display("unexpected result word for job %0d", got.job_index);
                errors++;
                return;
            end
            exp = pending_recs.pop_front();
            if (got.job_index !== exp.job_index)
                report("job_index", 32'(got.job_index), 32'(exp.job_index));
            if (got.completion !== exp.completion)
                report("completion_tick", 32'(got.completion), 32'(exp.completion));
            if (got.turnaround !== exp.turnaround)
                report("turnaround_ticks", 32'(got.turnaround), 32'(exp.turnaround));
            if (got.waiting !== exp.waiting)
                report("waiting_ticks", 32'(got.waiting), 32'(exp.waiting));
            if (got.last_result !== exp.last_result)
                report("last_result", 32'(got.last_result), 32'(exp.last_result));
        endtask
    endclass

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [15:0]                    i_cfg_wdata;
    logic                           i_in_valid;
    logic                           o_in_stall;
    logic [rrs_pkg::TIME_WIDTH-1:0] i_arrival_time;
    logic [rrs_pkg::TIME_WIDTH-1:0] i_burst_time;
    logic                           i_last_job;
    logic                           o_out_valid;
    logic                           i_out_stall;
    logic [rrs_pkg::IDX_W-1:0]      o_job_index;
    logic [rrs_pkg::TICK_W-1:0]     o_completion_tick;
    logic [rrs_pkg::TICK_W-1:0]     o_turnaround_ticks;
    logic [rrs_pkg::TICK_W-1:0]     o_waiting_ticks;
    logic                           o_last_result;

    sched_scoreboard sb;
    bit              no_idle;
    bit              hold_req;
    int              cycle_count;
    int              jobs_sent;

    round_robin_schedule_sim_unit u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_arrival_time     (i_arrival_time),
        .i_burst_time       (i_burst_time),
        .i_last_job         (i_last_job),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_job_index        (o_job_index),
        .o_completion_tick  (o_completion_tick),
        .o_turnaround_ticks (o_turnaround_ticks),
        .o_waiting_ticks    (o_waiting_ticks),
        .o_last_result      (o_last_result)
    );

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycle_count);
                $display("round_robin_schedule_sim_unit_tb: errors");
                $finish;
            end
        end
    end

    // offer one job word, accepted at an edge with valid high and stall low
    task send_job(int unsigned arr, int unsigned bur, bit last);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            i_in_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1;
        i_arrival_time <= rrs_pkg::TIME_WIDTH'(arr);
        i_burst_time   <= rrs_pkg::TIME_WIDTH'(bur);
        i_last_job     <= last;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_job(arr, bur, last);
        jobs_sent++;
    endtask

    task drain();
        i_in_valid <= 0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task set_quantum(int unsigned q);
        drain();
        i_cfg_we    <= 1;
        i_cfg_wdata <= 16'(q);
        @(posedge i_clk);
        i_cfg_we <= 0;
        sb.quantum = q & 32'hFFFF;
    endtask

    task random_list(int len);
        for (int k = 0; k < len; k++)
            send_job($urandom_range(0, 40), $urandom_range(0, 24), k == len - 1);
    endtask

    // result side
    initial begin
        t_sched_rec got;
        int         hold;
        i_out_stall = 1;
        @(posedge i_rst_n);
        forever begin
            if (hold_req) begin
                hold = 400;
                hold_req = 0;
            end else begin
                hold = no_idle ? 0 : $urandom_range(0, 13);
            end
            if (hold > 0) begin
                i_out_stall <= 1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 0;
            do @(posedge i_clk); while (!o_out_valid);
            got.job_index   = o_job_index;
            got.completion  = o_completion_tick;
            got.turnaround  = o_turnaround_ticks;
            got.waiting     = o_waiting_ticks;
            got.last_result = o_last_result;
            sb.check(got);
        end
    end

    initial begin
        int len;
        sb = new();
        no_idle = 0;
        hold_req = 0;
        jobs_sent = 0;
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_wdata = 0;
        i_in_valid = 0;
        i_arrival_time = 0;
        i_burst_time = 0;
        i_last_job = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // default quantum, a zero-burst job last
        send_job(0, 3, 0);
        send_job(1, 5, 0);
        send_job(2, 0, 1);
        // smallest quantum, with idle ticks between arrivals
        set_quantum(1);
        send_job(3, 2, 0);
        send_job(0, 1, 0);
        send_job(9, 3, 1);
        // zero quantum behaves as one
        set_quantum(0);
        send_job(0, 3, 0);
        send_job(1, 2, 1);
        // largest quantum with the latest arrival and longest burst
        set_quantum(16'hFFFF);
        send_job(16'hFFFF, 16'hFFFF, 1);
        // overfull list: the seventeenth word is dropped but starts the run
        set_quantum(3);
        for (int k = 0; k < rrs_pkg::MAX_JOBS + 1; k++)
            send_job($urandom_range(0, 20), $urandom_range(1, 8), k == rrs_pkg::MAX_JOBS);

        // long output hold while the next list is offered
        drain();
        hold_req = 1;
        random_list(6);
        random_list(5);

        while (jobs_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 3) == 0)
                set_quantum(($urandom_range(0, 5) == 0) ? $urandom_range(9, 40)
                                                        : $urandom_range(1, 8));
            no_idle = ($urandom_range(0, 3) == 0);
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 18)
                                              : $urandom_range(1, 12);
            random_list(len);
        end
        no_idle = 0;
        drain();

        $display("ran %0d job words in %0d lists, %0d result words checked",
                 jobs_sent, sb.lists_done, sb.words_seen);
        $display("quanta from zero to 65535, zero bursts and overfull lists included");
        if (sb.errors == 0 && sb.pending() == 0)
            $display("round_robin_schedule_sim_unit_tb: clean");
        else
            $display("round_robin_schedule_sim_unit_tb: errors");
        $finish;
    end
endmodule
`default_nettype wire
